// ===== hdl/slt_pkg.sv =====
`default_nettype none

package slt_pkg;

	localparam int unsigned KEY_BITS = 32;
	localparam int unsigned PORT_PAYLOAD_BITS = 32;
	localparam int unsigned POS_BITS = 7;
	localparam int unsigned COUNT_BITS = 7;

	typedef enum logic [2:0] {
		OP_APPEND      = 3'd0,
		OP_HEAD_INSERT = 3'd1,
		OP_SORT_INSERT = 3'd2,
		OP_DROP_TAIL   = 3'd3,
		OP_DROP_HEAD   = 3'd4,
		OP_REMOVE_KEY  = 3'd5,
		OP_READ_POS    = 3'd6,
		OP_FIND_KEY    = 3'd7
	} op_t;

	typedef struct packed {
		op_t                           mode;
		logic signed [KEY_BITS-1:0]    entry_key;
		logic [PORT_PAYLOAD_BITS-1:0]  entry_payload;
		logic [POS_BITS-1:0]           position;
	} req_t;

	typedef struct packed {
		logic                          ok;
		logic [COUNT_BITS-1:0]         count;
		logic                          is_full;
		logic                          is_empty;
		logic signed [KEY_BITS-1:0]    found_key;
		logic [PORT_PAYLOAD_BITS-1:0]  found_payload;
	} rsp_t;

	// per-cell move command for the execute cycle
	typedef struct packed {
		logic load;
		logic shift_up;
		logic shift_down;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/slt_in_if.sv =====
`default_nettype none

interface slt_in_if;
	import slt_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/slt_out_if.sv =====
`default_nettype none

interface slt_out_if;
	import slt_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/slt_cell.sv =====
`default_nettype none

module slt_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW = 7,
	parameter int unsigned PW = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       capture,
	input  wire slt_pkg::op_t               mode,
	input  wire logic signed [31:0]         key_in,
	input  wire logic [CW-1:0]              count,
	output logic                            flag,
	input  wire slt_pkg::cell_ctrl_t        ctrl,
	input  wire logic [31:0]                new_key,
	input  wire logic [PW-1:0]              new_pay,
	input  wire logic [31:0]                left_key,
	input  wire logic [PW-1:0]              left_pay,
	input  wire logic [31:0]                right_key,
	input  wire logic [PW-1:0]              right_pay,
	output logic [31:0]                     key,
	output logic [PW-1:0]                   pay
);
	import slt_pkg::*;

	logic          occupied;
	logic          flag_d;
	logic          flag_s1;
	logic [31:0]   key_q;
	logic [PW-1:0] pay_q;

	assign occupied = CW'(IDX) < count;

	// mark the cells at which the operation may pivot; the lowest marked cell wins
	always_comb begin
		unique case (mode)
			OP_APPEND:      flag_d = !occupied;
			OP_HEAD_INSERT: flag_d = 1'b1;
			OP_SORT_INSERT: flag_d = !(occupied && ($signed(key_q) < key_in));
			OP_DROP_HEAD:   flag_d = 1'b1;
			OP_REMOVE_KEY:  flag_d = occupied && (key_q == key_in);
			OP_FIND_KEY:    flag_d = occupied && (key_q == key_in);
			default:        flag_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_s1 <= 1'b0;
		end else if (capture) begin
			flag_s1 <= flag_d;
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			key_q <= new_key;
			pay_q <= new_pay;
		end else if (ctrl.shift_up) begin
			key_q <= left_key;
			pay_q <= left_pay;
		end else if (ctrl.shift_down) begin
			key_q <= right_key;
			pay_q <= right_pay;
		end
	end

	assign flag = flag_s1;
	assign key  = key_q;
	assign pay  = pay_q;

endmodule

`default_nettype wire

// ===== hdl/sequential_list_table.sv =====
// Packed record list built as a row of cells, one record per cell.
// req carries one operation per beat (mode, entry_key, entry_payload,
// position); rsp returns one beat per request with ok, count after the
// operation, is_full, is_empty and, for read and find, the record.
// Each request runs in steps: the cells compare against the key on
// the accept edge, the pivot state isolates the lowest flagged cell with
// one CAPACITY-wide add, and the execute state loads or moves the cells
// from the pivot upward by one slot at once, as the operation needs, and
// loads the response register. A response is valid once the execute state
// has fired; the next request is taken once the execute state has
// completed, so no request is taken before the previous one is through.
// The selected record is an OR across all cells in the execute state.
// If rsp is stalled, the block holds in its execute cycle and req stays
// not ready; nothing is dropped. The response register lets a new request
// be accepted while the previous response still waits.
// Reset clears the record count and the handshake state; cell contents
// are not cleared, since only cells below the count are ever read.
`default_nettype none

module sequential_list_table #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	slt_in_if.sink     req,
	slt_out_if.source  rsp
);
	import slt_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = PAYLOAD_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PIVOT,
		ST_EXEC
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	op_t             mode_q;
	logic [31:0]     key_q;
	logic [PW-1:0]   pay_q;
	logic [POS_BITS-1:0] pos_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic                accept;
	logic                fire;
	logic [CAPACITY-1:0] flag;
	logic [CAPACITY-1:0] flag_neg;
	logic [CAPACITY-1:0] mask_s2;
	logic [CAPACITY-1:0] low_s2;
	logic [CAPACITY-1:0] sel_d;
	logic [CAPACITY-1:0] sel_s2;
	logic                ok_d;
	logic                ok_s2;
	logic [CW-1:0]       count_next;
	logic [31:0]         found_key;
	logic [PW-1:0]       found_pay;

	logic [31:0]         cell_key [CAPACITY];
	logic [PW-1:0]       cell_pay [CAPACITY];
	cell_ctrl_t          cell_ctrl [CAPACITY];

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign fire      = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);

	// isolate the lowest flagged cell and everything above it
	assign flag_neg = ~flag + CAPACITY'(1);

	always_comb begin
		unique case (mode_q)
			OP_APPEND, OP_HEAD_INSERT, OP_SORT_INSERT:
				ok_d = (count_q != CW'(CAPACITY));
			OP_DROP_TAIL, OP_DROP_HEAD:
				ok_d = (count_q != '0);
			OP_REMOVE_KEY, OP_FIND_KEY:
				ok_d = |flag;
			OP_READ_POS:
				ok_d = (pos_q != '0) && (32'(pos_q) <= 32'(count_q));
			default:
				ok_d = 1'b0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			unique case (mode_q)
				OP_READ_POS: sel_d[i] = ok_d && (32'(pos_q) == 32'(i + 1));
				OP_FIND_KEY: sel_d[i] = flag[i] & flag_neg[i];
				default:     sel_d[i] = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.data.mode;
			key_q  <= req.data.entry_key;
			pay_q  <= PW'(req.data.entry_payload);
			pos_q  <= req.data.position;
		end
		if (state_q == ST_PIVOT) begin
			mask_s2 <= flag | flag_neg;
			low_s2  <= flag & flag_neg;
			sel_s2  <= sel_d;
			ok_s2   <= ok_d;
		end
	end

	// load or move the cells from the pivot upward by one slot in the execute cycle
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_ctrl[i] = '0;
			if (fire && ok_s2) begin
				unique case (mode_q)
					OP_APPEND, OP_HEAD_INSERT, OP_SORT_INSERT: begin
						cell_ctrl[i].load     = low_s2[i];
						cell_ctrl[i].shift_up = mask_s2[i] & ~low_s2[i];
					end
					OP_DROP_HEAD, OP_REMOVE_KEY: begin
						cell_ctrl[i].shift_down = mask_s2[i];
					end
					default: begin
						cell_ctrl[i] = '0;
					end
				endcase
			end
		end
	end

	always_comb begin
		found_key = '0;
		found_pay = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			found_key = found_key | (sel_s2[i] ? cell_key[i] : '0);
			found_pay = found_pay | (sel_s2[i] ? cell_pay[i] : '0);
		end
	end

	always_comb begin
		count_next = count_q;
		if (ok_s2) begin
			unique case (mode_q)
				OP_APPEND, OP_HEAD_INSERT, OP_SORT_INSERT:
					count_next = count_q + CW'(1);
				OP_DROP_TAIL, OP_DROP_HEAD, OP_REMOVE_KEY:
					count_next = count_q - CW'(1);
				default:
					count_next = count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PIVOT;
					end
				end
				ST_PIVOT: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
						count_q <= count_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.ok            <= ok_s2;
			rsp_q.count         <= COUNT_BITS'(count_next);
			rsp_q.is_full       <= (count_next == CW'(CAPACITY));
			rsp_q.is_empty      <= (count_next == '0);
			rsp_q.found_key     <= found_key;
			rsp_q.found_payload <= PORT_PAYLOAD_BITS'(found_pay);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [31:0]   left_key;
		logic [PW-1:0] left_pay;
		logic [31:0]   right_key;
		logic [PW-1:0] right_pay;

		if (g == 0) begin : g_first
			assign left_key = key_q;
			assign left_pay = pay_q;
		end else begin : g_inner_l
			assign left_key = cell_key[g-1];
			assign left_pay = cell_pay[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_key = cell_key[g];
			assign right_pay = cell_pay[g];
		end else begin : g_inner_r
			assign right_key = cell_key[g+1];
			assign right_pay = cell_pay[g+1];
		end

		slt_cell #(
			.IDX (g),
			.CW  (CW),
			.PW  (PW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.capture   (accept),
			.mode      (req.data.mode),
			.key_in    (req.data.entry_key),
			.count     (count_q),
			.flag      (flag[g]),
			.ctrl      (cell_ctrl[g]),
			.new_key   (key_q),
			.new_pay   (pay_q),
			.left_key  (left_key),
			.left_pay  (left_pay),
			.right_key (right_key),
			.right_pay (right_pay),
			.key       (cell_key[g]),
			.pay       (cell_pay[g])
		);
	end

endmodule

`default_nettype wire
